// File: rtl/msq_pkg.sv
// package for the marching squares segment generator
// shared types, sizes and the fixed cell-mask to segment tables; no dependencies
package msq_pkg;

   localparam int COORD_W    = 11;
   localparam int CFG_W      = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

   typedef enum logic [2:0] {
      SH_UL,
      SH_UR,
      SH_LR,
      SH_LL,
      SH_HZ,
      SH_VT
   } shape_type;

   // segment end points in doubled cell-local coordinates
   typedef struct packed {
      logic [1:0] sx;
      logic [1:0] sy;
      logic [1:0] ex;
      logic [1:0] ey;
   } points_type;

   // one cell with at least one segment, queued between front and back
   typedef struct packed {
      logic [3:0]         mask;
      logic [COORD_W-1:0] bx;
      logic [COORD_W-1:0] by;
   } cell_type;

   function automatic logic [1:0] seg_count(input logic [3:0] mask);
      logic [1:0] n;
      case (mask)
         4'd0, 4'd15: n = 2'd0;
         4'd5, 4'd10: n = 2'd2;
         default:     n = 2'd1;
      endcase
      return n;
   endfunction

   function automatic shape_type seg_shape(input logic [3:0] mask, input logic second);
      shape_type s;
      case (mask)
         4'd1, 4'd14: s = SH_UL;
         4'd2, 4'd13: s = SH_UR;
         4'd3, 4'd12: s = SH_HZ;
         4'd4, 4'd11: s = SH_LR;
         4'd5:        s = second ? SH_UR : SH_LL;
         4'd6, 4'd9:  s = SH_VT;
         4'd7, 4'd8:  s = SH_LL;
         4'd10:       s = second ? SH_LR : SH_UL;
         default:     s = SH_UL;
      endcase
      return s;
   endfunction

   function automatic points_type shape_points(input shape_type s);
      points_type p;
      case (s)
         SH_UL:   p = '{sx: 2'd0, sy: 2'd1, ex: 2'd1, ey: 2'd0};
         SH_UR:   p = '{sx: 2'd1, sy: 2'd0, ex: 2'd2, ey: 2'd1};
         SH_LR:   p = '{sx: 2'd2, sy: 2'd1, ex: 2'd1, ey: 2'd2};
         SH_LL:   p = '{sx: 2'd1, sy: 2'd2, ex: 2'd0, ey: 2'd1};
         SH_HZ:   p = '{sx: 2'd0, sy: 2'd1, ex: 2'd2, ey: 2'd1};
         SH_VT:   p = '{sx: 2'd1, sy: 2'd0, ex: 2'd1, ey: 2'd2};
         default: p = '{sx: 2'd0, sy: 2'd0, ex: 2'd0, ey: 2'd0};
      endcase
      return p;
   endfunction

endpackage

// File: rtl/msq_ifs.sv
// channel interfaces of the marching squares segment generator
// pixel, segment and register write channels; depends on msq_pkg
interface msq_req_if;
   logic valid;
   logic ready;
   logic pixel_on;
   modport source (output valid, output pixel_on, input ready);
   modport sink (input valid, input pixel_on, output ready);
endinterface

interface msq_rsp_if
   import msq_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] start_x2;
   logic [COORD_W-1:0] start_y2;
   logic [COORD_W-1:0] end_x2;
   logic [COORD_W-1:0] end_y2;
   logic               last_of_cell;
   modport source (output valid, output start_x2, output start_y2, output end_x2,
                   output end_y2, output last_of_cell, input ready);
   modport sink (input valid, input start_x2, input start_y2, input end_x2,
                 input end_y2, input last_of_cell, output ready);
endinterface

interface msq_csr_if
   import msq_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CFG_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/msq_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module msq_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/msq_front.sv
// front end: size registers, raster counters, row store and cell mask forming
// depends on msq_pkg and msq_ram
module msq_front
   import msq_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 pixel_on,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 fifo_full,
   output logic                 push,
   output cell_type             push_cell
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int SW = ((CW > CFG_W) ? CW : CFG_W) + 2;
   localparam logic [SW-1:0] MAX_W_S = SW'(MAX_WIDTH);
   localparam logic [SW-1:0] MAX_H_S = SW'(MAX_HEIGHT);
   localparam logic [SW-1:0] MIN_S   = SW'(2);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic             left_ff, left_in;
   logic             upleft_ff, upleft_in;

   logic [SW-1:0] w_eff, h_eff, w_raw, h_raw;
   logic [SW-1:0] col_next, row_next;
   logic          accept;
   logic          above;
   logic [3:0]    mask;
   logic [CW-1:0] col_m1;
   logic [RW-1:0] row_m1;

   assign req_ready = !fifo_full;
   assign accept    = req_valid && req_ready;

   // clamp the size registers to the supported range
   always_comb begin
      w_raw = SW'(width_ff);
      h_raw = SW'(height_ff);
      w_eff = (w_raw < MIN_S) ? MIN_S : ((w_raw > MAX_W_S) ? MAX_W_S : w_raw);
      h_eff = (h_raw < MIN_S) ? MIN_S : ((h_raw > MAX_H_S) ? MAX_H_S : h_raw);
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // raster position
   always_comb begin
      col_next  = SW'(col_ff) + SW'(1);
      row_next  = SW'(row_ff) + SW'(1);
      col_in    = col_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      upleft_in = upleft_ff;
      if (accept) begin
         left_in   = pixel_on;
         upleft_in = above;
         if (col_next >= w_eff) begin
            col_in = '0;
            row_in = (row_next >= h_eff) ? '0 : row_next[RW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
      if (reset) begin
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         left_ff   <= 1'b0;
         upleft_ff <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         left_ff   <= left_in;
         upleft_ff <= upleft_in;
      end
   end

   // read ahead at the next column so the pixel above is ready on accept
   msq_ram #(
      .WIDTH (1),
      .DEPTH (MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (pixel_on),
      .rd_addr (col_in),
      .rd_data (above)
   );

   assign mask   = {left_ff, pixel_on, above, upleft_ff};
   assign col_m1 = col_ff - CW'(1);
   assign row_m1 = row_ff - RW'(1);

   assign push_cell = '{mask: mask,
                        bx:   COORD_W'({col_m1, 1'b0}),
                        by:   COORD_W'({row_m1, 1'b0})};
   assign push      = accept && (col_ff != '0) && (row_ff != '0) && (seg_count(mask) != 2'd0);

endmodule

// File: rtl/msq_fifo.sv
// short cell queue between front and back
// depends on msq_pkg
module msq_fifo
   import msq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cell_type push_cell,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output cell_type head
);

   cell_type             entry_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;

   assign full      = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cell;
      end
   end

endmodule

// File: rtl/msq_back.sv
// back end: expands queued cells into segments into the output register
// depends on msq_pkg
module msq_back
   import msq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cell_valid,
   input  cell_type           head_cell,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COORD_W-1:0] start_x2,
   output logic [COORD_W-1:0] start_y2,
   output logic [COORD_W-1:0] end_x2,
   output logic [COORD_W-1:0] end_y2,
   output logic               last_of_cell
);

   logic               valid_ff, valid_in;
   logic               second_ff, second_in;
   logic [COORD_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic               last_ff;
   logic               load;
   logic               is_last;
   points_type         pts;

   assign load    = cell_valid && (!valid_ff || rsp_ready);
   assign is_last = second_ff || (seg_count(head_cell.mask) == 2'd1);
   assign pts     = shape_points(seg_shape(head_cell.mask, second_ff));
   assign pop     = load && is_last;

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      if (load) begin
         valid_in  = 1'b1;
         second_in = !is_last;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sx_ff   <= head_cell.bx + COORD_W'(pts.sx);
         sy_ff   <= head_cell.by + COORD_W'(pts.sy);
         ex_ff   <= head_cell.bx + COORD_W'(pts.ex);
         ey_ff   <= head_cell.by + COORD_W'(pts.ey);
         last_ff <= is_last;
      end
   end

   assign rsp_valid    = valid_ff;
   assign start_x2     = sx_ff;
   assign start_y2     = sy_ff;
   assign end_x2       = ex_ff;
   assign end_y2       = ey_ff;
   assign last_of_cell = last_ff;

endmodule

// File: rtl/marching_squares_segments.sv
// top level of the marching squares segment generator
// depends on msq_pkg, msq_ifs, msq_front, msq_fifo, msq_back and msq_ram
//
// takes a binary image one pixel per req transaction in raster order and, for every
// complete 2x2 cell, sends zero, one or two line segments as rsp transactions with
// end points in half-pixel units (start and end x/y, each 2*x) and last_of_cell set on
// the final segment of the cell; cells in the first row or column produce nothing, and
// the saddle masks 5 and 10 produce two segments that keep the lit corners joined.
// a pixel is taken every cycle while the cell queue has room; the output register
// moves one segment per cycle while rsp is ready, so the sustained rate is one pixel
// per cycle for cells with at most one segment, while the two segments of a saddle
// cell are bound by the rsp port. the previous row lives in a ram of MAX_WIDTH
// one-bit words read one column ahead; its content is undefined after reset and is
// only used once a row has been written, so no clearing pass is needed.
// image_width (index 0) and image_height (index 1) reset to 1024 and are clamped to
// [2, MAX_WIDTH] and [2, MAX_HEIGHT]; write them only while the block is idle
module marching_squares_segments
   import msq_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input logic         clock,
   input logic         reset,
   msq_req_if.sink     req_ch,
   msq_rsp_if.source   rsp_ch,
   msq_csr_if.sink     csr_ch
);

   // front to queue
   logic     push;
   cell_type push_cell;
   logic     fifo_full;

   // queue to back
   logic     cell_valid;
   cell_type head_cell;
   logic     pop;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;

   // counters, row store and mask forming; stalls only when the queue is full
   msq_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .pixel_on  (req_ch.pixel_on),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .fifo_full (fifo_full),
      .push      (push),
      .push_cell (push_cell)
   );

   // only cells that carry segments are queued
   msq_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cell (push_cell),
      .pop       (pop),
      .full      (fifo_full),
      .not_empty (cell_valid),
      .head      (head_cell)
   );

   // one segment per cycle into the output register while rsp is ready
   msq_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cell_valid   (cell_valid),
      .head_cell    (head_cell),
      .pop          (pop),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .start_x2     (rsp_ch.start_x2),
      .start_y2     (rsp_ch.start_y2),
      .end_x2       (rsp_ch.end_x2),
      .end_y2       (rsp_ch.end_y2),
      .last_of_cell (rsp_ch.last_of_cell)
   );

endmodule

// File: rtl/msq_checker.sv
// port-level checks of the marching squares segment generator
// depends on msq_pkg; bound to marching_squares_segments
module msq_checker
   import msq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COORD_W-1:0] start_x2,
   input logic [COORD_W-1:0] start_y2,
   input logic [COORD_W-1:0] end_x2,
   input logic [COORD_W-1:0] end_y2,
   input logic               last_of_cell
);

   // a stalled segment stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // a stalled segment keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(start_x2) && $stable(start_y2)
         && $stable(end_x2) && $stable(end_y2) && $stable(last_of_cell))
      else $error("rsp payload changed while stalled");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // only a saddle cell has a first segment, and that one is a corner cut
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !last_of_cell |-> (start_x2[0] != end_x2[0]) && (start_y2[0] != end_y2[0]))
      else $error("non-final segment is not a corner cut");

endmodule

bind marching_squares_segments msq_checker u_msq_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .start_x2     (rsp_ch.start_x2),
   .start_y2     (rsp_ch.start_y2),
   .end_x2       (rsp_ch.end_x2),
   .end_y2       (rsp_ch.end_y2),
   .last_of_cell (rsp_ch.last_of_cell)
);

// File: sim/tb_marching_squares_segments.sv
// testbench for the marching squares segment generator
// streams binary images, predicts every segment and checks each rsp transaction in order
// depends on msq_pkg, msq_ifs and marching_squares_segments
module tb_marching_squares_segments;
   import msq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SIDE       = 1024;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 8;      // drain time after the last expected segment
   localparam int RANDOM_PIXELS  = 700;
   localparam int WIDE_PIXELS    = MAX_SIDE + 64;
   localparam int TALL_PIXELS    = 128;
   localparam int STALL_CYCLES   = 300;
   localparam int REPORT_CAP     = 200;
   localparam int RUN_LIMIT_NS   = 80_000_000;

   // one expected or observed segment
   typedef struct packed {
      logic [COORD_W-1:0] start_x2;
      logic [COORD_W-1:0] start_y2;
      logic [COORD_W-1:0] end_x2;
      logic [COORD_W-1:0] end_y2;
      logic               last_of_cell;
   } segment_type;

   // image content generators for the pixel streams
   typedef enum int {
      PAT_NOISE,
      PAT_CHECKER,
      PAT_BLOB,
      PAT_BANDS
   } pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msq_req_if req_ch ();
   msq_rsp_if rsp_ch ();
   msq_csr_if csr_ch ();

   marching_squares_segments #(
      .MAX_WIDTH  (MAX_SIDE),
      .MAX_HEIGHT (MAX_SIDE)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------
   // contour predictor state, a mirror of the block's registers and line buffer
   // ---------------------------------------------------------------------------
   logic [CFG_W-1:0] width_reg  = SIZE_RESET;
   logic [CFG_W-1:0] height_reg = SIZE_RESET;
   bit               row_bits    [MAX_SIDE];
   bit               row_written [MAX_SIDE];   // entries the image has filled so far
   logic             left_px        = 1'b0;
   logic             upper_left_px  = 1'b0;
   int unsigned      col_pos        = 0;
   int unsigned      row_pos        = 0;

   segment_type      expected_segments [$];

   // run statistics and the error tally
   int unsigned      mismatch_count = 0;
   int unsigned      reported       = 0;
   int unsigned      pixel_count    = 0;
   int unsigned      segment_count  = 0;
   int unsigned      saddle_cells   = 0;
   int unsigned      reg_writes     = 0;

   // flow control knobs shared by the stimulus and the rsp side
   bit               send_steady = 1'b0;
   bit               take_steady = 1'b0;
   int unsigned      rsp_hold    = 0;
   int unsigned      take_gap    = 0;

   string            field_names [5] = '{"start_x2", "start_y2", "end_x2", "end_y2",
                                         "last_of_cell"};

   // the size registers are clamped to [2, MAX_SIDE]
   function automatic int unsigned eff_size(input logic [CFG_W-1:0] raw);
      if (raw < 2) return 2;
      if (raw > MAX_SIDE) return MAX_SIDE;
      return raw;
   endfunction

   // cell mask (bit0 ul, bit1 ur, bit2 lr, bit3 ll) to its segment shapes;
   // the saddles keep the two lit corners joined
   function automatic void cell_segments(input logic [3:0] mask, output int unsigned count,
                                         output shape_type first, output shape_type second);
      count  = 1;
      first  = SH_UL;
      second = SH_UL;
      case (mask)
         4'd0, 4'd15: count = 0;
         4'd1, 4'd14: first = SH_UL;
         4'd2, 4'd13: first = SH_UR;
         4'd3, 4'd12: first = SH_HZ;
         4'd4, 4'd11: first = SH_LR;
         4'd6, 4'd9:  first = SH_VT;
         4'd7, 4'd8:  first = SH_LL;
         4'd5: begin
            count  = 2;
            first  = SH_LL;
            second = SH_UR;
         end
         default: begin
            count  = 2;
            first  = SH_UL;
            second = SH_LR;
         end
      endcase
   endfunction

   // doubled cell-local end points {sx, sy, ex, ey}
   function automatic logic [7:0] shape_offsets(input shape_type s);
      case (s)
         SH_UL:   return {2'd0, 2'd1, 2'd1, 2'd0};
         SH_UR:   return {2'd1, 2'd0, 2'd2, 2'd1};
         SH_LR:   return {2'd2, 2'd1, 2'd1, 2'd2};
         SH_LL:   return {2'd1, 2'd2, 2'd0, 2'd1};
         SH_HZ:   return {2'd0, 2'd1, 2'd2, 2'd1};
         default: return {2'd1, 2'd0, 2'd1, 2'd2};
      endcase
   endfunction

   // advance the predictor by one accepted pixel and queue the segments it closes
   function automatic void march_pixel(input logic px);
      int unsigned w, h, c, r, count;
      logic        above;
      logic [3:0]  mask;
      shape_type   shapes [2];
      logic [7:0]  offs;
      logic [COORD_W-1:0] base_x, base_y;
      segment_type seg;
      w     = eff_size(width_reg);
      h     = eff_size(height_reg);
      c     = col_pos;
      r     = row_pos;
      above = row_bits[c];
      // no cell in the first row or the first column
      if (c >= 1 && r >= 1) begin
         mask   = {left_px, px, above, upper_left_px};
         cell_segments(mask, count, shapes[0], shapes[1]);
         base_x = COORD_W'(2 * (c - 1));
         base_y = COORD_W'(2 * (r - 1));
         for (int k = 0; k < count; k++) begin
            offs             = shape_offsets(shapes[k]);
            seg.start_x2     = base_x + COORD_W'(offs[7:6]);
            seg.start_y2     = base_y + COORD_W'(offs[5:4]);
            seg.end_x2       = base_x + COORD_W'(offs[3:2]);
            seg.end_y2       = base_y + COORD_W'(offs[1:0]);
            seg.last_of_cell = (k == count - 1);
            expected_segments.push_back(seg);
         end
         if (count == 2) saddle_cells++;
      end
      upper_left_px  = above;
      row_bits[c]    = px;
      row_written[c] = 1'b1;
      left_px        = px;
      // counts past a shrunken size wrap after this pixel; frame end restarts at row 0
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // port watcher: register writes, accepted pixels and segment checks, all
   // sampled at the rising edge
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : port_watch
      segment_type        got, want;
      logic [COORD_W-1:0] got_f [5];
      logic [COORD_W-1:0] want_f [5];
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = '{rsp_ch.start_x2, rsp_ch.start_y2, rsp_ch.end_x2, rsp_ch.end_y2,
                    rsp_ch.last_of_cell};
            segment_count++;
            if (expected_segments.size() == 0) begin
               mismatch_count++;
               if (reported < REPORT_CAP) begin
                  reported++;
                  $display("%0t: segment with nothing expected, got (%0d,%0d)->(%0d,%0d) last %0d",
                           $time, got.start_x2, got.start_y2, got.end_x2, got.end_y2,
                           got.last_of_cell);
               end
            end else begin
               want   = expected_segments.pop_front();
               got_f  = '{got.start_x2, got.start_y2, got.end_x2, got.end_y2,
                          COORD_W'(got.last_of_cell)};
               want_f = '{want.start_x2, want.start_y2, want.end_x2, want.end_y2,
                          COORD_W'(want.last_of_cell)};
               for (int f = 0; f < 5; f++) begin
                  if (got_f[f] !== want_f[f]) begin
                     mismatch_count++;
                     if (reported < REPORT_CAP) begin
                        reported++;
                        $display("%0t: %s expected %0d, got %0d", $time, field_names[f],
                                 want_f[f], got_f[f]);
                     end
                  end
               end
            end
         end
         if (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1) begin
            reg_writes++;
            if (csr_ch.index == CSR_IMAGE_WIDTH) width_reg = csr_ch.data;
            else if (csr_ch.index == CSR_IMAGE_HEIGHT) height_reg = csr_ch.data;
         end
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            pixel_count++;
            march_pixel(req_ch.pixel_on);
         end
      end
   end

   // idle length for either side: mostly none or short, now and then long
   function automatic int unsigned idle_span(input bit steady);
      int unsigned roll;
      roll = $urandom_range(99);
      if (steady || roll < 60) return 0;
      if (roll < 90) return $urandom_range(3, 1);
      if (roll < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // rsp side: random stalls, plus a long hold-off counted here when asked for
   always @(negedge clock) begin : take_side
      if (rsp_hold > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else if (take_gap > 0) begin
         rsp_ch.ready <= 1'b0;
         take_gap = take_gap - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         take_gap = idle_span(take_steady);
      end
   end

   // ---------------------------------------------------------------------------
   // drivers, changing inputs at the falling edge
   // ---------------------------------------------------------------------------

   // one pixel transaction; valid stays high afterwards so back-to-back pixels
   // need no extra edge, wait_idle lowers it
   task automatic send_pixel(input logic px);
      int unsigned gap;
      gap = idle_span(send_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.pixel_on <= px;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   task automatic write_size_reg(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // stop offering pixels, wait for every queued segment, then let the pipe drain
   // of cells that produce nothing
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_segments.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // stream pixels of one image pattern, tracking the raster position locally;
   // with to_frame_start it runs until the next frame begins instead of count pixels.
   // call only while the predictor is settled (after wait_idle or a register write)
   task automatic stream_pixels(input int unsigned count, input pattern_type pat,
                                input bit to_frame_start);
      int unsigned c, r, w, h, sent, density, x0, x1, y0, y1, band;
      bit          horiz;
      logic        px;
      c       = col_pos;
      r       = row_pos;
      w       = eff_size(width_reg);
      h       = eff_size(height_reg);
      density = $urandom_range(95, 5);
      x0      = $urandom_range(w - 1);
      x1      = $urandom_range(w - 1, x0);
      y0      = $urandom_range(h - 1);
      y1      = $urandom_range(h - 1, y0);
      band    = $urandom_range(4, 1);
      horiz   = 1'($urandom_range(1));
      sent    = 0;
      while (to_frame_start ? (c != 0 || r != 0) : (sent < count)) begin
         case (pat)
            PAT_NOISE:   px = ($urandom_range(99) < density);
            PAT_CHECKER: px = 1'((c + r) % 2);     // every interior cell is a saddle
            PAT_BLOB:    px = (c >= x0 && c <= x1 && r >= y0 && r <= y1);
            default:     px = 1'(((horiz ? r : c) / band) % 2);
         endcase
         send_pixel(px);
         if (c + 1 >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            c++;
         end
         sent++;
      end
   endtask

   // a width write is allowed only if the rows it makes the block read are filled
   function automatic bit width_fits(input logic [CFG_W-1:0] raw);
      if (row_pos == 0) return 1'b1;
      for (int i = col_pos; i < eff_size(raw); i++) begin
         if (!row_written[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [CFG_W-1:0] random_size();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 75) return CFG_W'($urandom_range(12, 2));
      if (roll < 90) return CFG_W'($urandom_range(40, 13));
      if (roll < 96) return CFG_W'($urandom_range(1));           // clamps up to 2
      return CFG_W'($urandom_range(2047, MAX_SIDE));              // clamps down to max
   endfunction

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   // all 16 cell masks in one 17x2 frame: each column is a (top, bottom) pair and
   // the column sequence holds every ordered pair once, so the cells see every mask,
   // both saddles included; the first row and column give nothing
   task automatic test_cell_masks();
      logic [1:0] corners [17];
      corners = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
                  2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
      write_size_reg(CSR_IMAGE_WIDTH, 11'd17);
      write_size_reg(CSR_IMAGE_HEIGHT, 11'd2);
      for (int i = 0; i < 17; i++) send_pixel(corners[i][1]);
      for (int i = 0; i < 17; i++) send_pixel(corners[i][0]);
   endtask

   // sizes below the minimum clamp to 2, and shrinking mid-frame wraps the counts
   task automatic test_size_change();
      wait_idle();
      write_size_reg(CSR_IMAGE_WIDTH, 11'd4);
      write_size_reg(CSR_IMAGE_HEIGHT, 11'd3);
      stream_pixels(6, PAT_NOISE, 1'b0);
      wait_idle();
      write_size_reg(CSR_IMAGE_WIDTH, 11'd0);
      write_size_reg(CSR_IMAGE_HEIGHT, 11'd1);
      stream_pixels(5, PAT_NOISE, 1'b0);
   endtask

   // widest rows: an oversized width clamps to the maximum, so the first row runs
   // the full line buffer and wraps there into the first cells of the next row
   task automatic test_widest_rows();
      wait_idle();
      stream_pixels(0, PAT_NOISE, 1'b1);
      wait_idle();
      write_size_reg(CSR_IMAGE_WIDTH, 11'd2047);
      write_size_reg(CSR_IMAGE_HEIGHT, 11'd2);
      stream_pixels(WIDE_PIXELS, PAT_NOISE, 1'b0);
   endtask

   // oversized height with the narrowest rows, the rows run on past every small size
   task automatic test_tallest_frame();
      wait_idle();
      write_size_reg(CSR_IMAGE_WIDTH, 11'd2);
      write_size_reg(CSR_IMAGE_HEIGHT, 11'd1536);
      stream_pixels(TALL_PIXELS, PAT_NOISE, 1'b0);
   endtask

   // rsp held off for a long stretch while saddle-only pixels keep coming, so the
   // cell queue fills and req must stall; then the sender waits for a full drain
   task automatic test_output_stall();
      wait_idle();
      write_size_reg(CSR_IMAGE_WIDTH, 11'd6);
      write_size_reg(CSR_IMAGE_HEIGHT, 11'd6);
      send_steady = 1'b1;
      take_steady = 1'b0;
      rsp_hold    = STALL_CYCLES;
      stream_pixels(72, PAT_CHECKER, 1'b0);
      send_steady = 1'b0;
      wait_idle();
   endtask

   // random phases: new sizes at whatever frame position the stream has reached,
   // random image patterns, with and without idling on either side
   task automatic test_random_frames();
      int unsigned      sent, n;
      logic [CFG_W-1:0] raw_w;
      pattern_type      pat;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         wait_idle();
         send_steady = ($urandom_range(4) == 0);
         take_steady = ($urandom_range(4) == 0);
         if ($urandom_range(2) != 0) begin
            raw_w = random_size();
            // a wider row could read line buffer entries never filled: finish the frame
            if (!width_fits(raw_w)) begin
               stream_pixels(0, PAT_NOISE, 1'b1);
               wait_idle();
            end
            write_size_reg(CSR_IMAGE_WIDTH, raw_w);
         end
         if ($urandom_range(2) != 0) write_size_reg(CSR_IMAGE_HEIGHT, random_size());
         n   = $urandom_range(120, 20);
         pat = pattern_type'($urandom_range(3));
         stream_pixels(n, pat, 1'b0);
         sent += n;
      end
      send_steady = 1'b0;
      take_steady = 1'b0;
   endtask

   initial begin : run_tests
      req_ch.valid    = 1'b0;
      req_ch.pixel_on = 1'b0;
      csr_ch.valid    = 1'b0;
      csr_ch.index    = CSR_IMAGE_WIDTH;
      csr_ch.data     = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_cell_masks();
      test_size_change();
      test_widest_rows();
      test_tallest_frame();
      test_output_stall();
      test_random_frames();
      wait_idle();

      $display("covered %0d pixels and %0d segments, %0d of the cells saddles, %0d size writes",
               pixel_count, segment_count, saddle_cells, reg_writes);
      $display("every cell mask, clamped and mid-frame sizes, a full-width row and a long stall");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("timeout with %0d segments still expected", expected_segments.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: files.f
rtl/msq_pkg.sv
rtl/msq_ifs.sv
rtl/msq_ram.sv
rtl/msq_front.sv
rtl/msq_fifo.sv
rtl/msq_back.sv
rtl/marching_squares_segments.sv
rtl/msq_checker.sv
sim/tb_marching_squares_segments.sv
